/* sv/mwm_pkg.sv */
// Shared types and constants for the MRU window map cache.
package mwm_pkg;

    localparam int WAYS        = 8;
    localparam int OFFSET_BITS = 15;
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS;
    localparam int IDX_W       = $clog2(WAYS);
    localparam int WIN_IDX_W   = 3;
    localparam int WIN_OFF_W   = 15;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_INVAL = 1'b1;

    // In-window offset mask with the byte-in-word bits cleared
    localparam logic [ADDR_W-1:0] OFF_MASK =
        ((ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1)) & ~ADDR_W'(3);

    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [IDX_W-1:0] win_t;

    // Request presented to the entry array
    typedef struct packed {
        logic update;
        logic op;
        tag_t tag;
    } mwm_cmd_t;

    // Lookup outcome against the current entry state
    typedef struct packed {
        win_t win;
        logic hit;
        logic evicted;
    } mwm_lookup_t;

endpackage

/* sv/mwm_if.sv */
// Valid/ready channel interfaces for map requests and results.
interface mwm_req_if;
    import mwm_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] phys_addr;

    modport source (output valid, output op, output phys_addr, input ready);
    modport sink   (input valid, input op, input phys_addr, output ready);
endinterface

interface mwm_rsp_if;
    import mwm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WIN_IDX_W-1:0] window_index;
    logic [WIN_OFF_W-1:0] window_offset;
    logic                 hit;
    logic                 evicted;

    modport source (output valid, output window_index, output window_offset,
                    output hit, output evicted, input ready);
    modport sink   (input valid, input window_index, input window_offset,
                    input hit, input evicted, output ready);
endinterface

/* sv/mru_window_map_cache.sv */
// Top level of the MRU window map cache: input register, entry array, result register.
//
// Usage notes:
//   req  : map requests. op = map (0) looks up phys_addr, op = invalidate (1)
//          frees every entry. An item is taken when req.valid && req.ready.
//   rsp  : one result per request: window number, word-aligned offset in the
//          window, hit and evicted flags. Invalidate results are all zero.
//   Path: a request goes from accept into the input register, then through
//          lookup and entry update into the result register.
//   Throughput: 1 item per cycle while rsp.ready is high. The tag compare across
//          all entries and the one-place shift of the entry array both complete
//          as an item advances, so it sees the state left by the one before it.
//   Stall: when rsp.ready is low the result holds; the input register still
//          takes one more item, then req.ready drops until the result moves.
//   Reset: rst_n (async, active low) empties both registers, clears every
//          entry's valid bit and puts window i in entry i.
module mru_window_map_cache
    import mwm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mwm_req_if.sink      req,
    mwm_rsp_if.source    rsp
);

    // input register
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // result register
    logic                 out_valid_reg;
    logic [WIN_IDX_W-1:0] out_index_reg;
    logic [WIN_OFF_W-1:0] out_offset_reg;
    logic                 out_hit_reg;
    logic                 out_evicted_reg;

    logic                 advance;
    mwm_cmd_t             cmd;
    mwm_lookup_t          lookup;
    logic [ADDR_W-1:0]    offset_full;
    logic [ADDR_W-1:0]    win_full;

    // item moves from input register into result register
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    assign cmd.update = advance;
    assign cmd.op     = s1_op_reg;
    assign cmd.tag    = s1_addr_reg[ADDR_W-1:OFFSET_BITS];

    mwm_entries u_entries
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .lookup (lookup)
    );

    assign offset_full = s1_addr_reg & OFF_MASK;
    assign win_full    = ADDR_W'(lookup.win);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg   <= req.op;
            s1_addr_reg <= req.phys_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s1_op_reg == OP_INVAL)
            begin
                out_index_reg   <= '0;
                out_offset_reg  <= '0;
                out_hit_reg     <= 1'b0;
                out_evicted_reg <= 1'b0;
            end
            else
            begin
                out_index_reg   <= win_full[WIN_IDX_W-1:0];
                out_offset_reg  <= offset_full[WIN_OFF_W-1:0];
                out_hit_reg     <= lookup.hit;
                out_evicted_reg <= lookup.evicted;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.window_index  = out_index_reg;
    assign rsp.window_offset = out_offset_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.evicted       = out_evicted_reg;

    // a result is never both a hit and an eviction
    a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.evicted))
        else $error("result flagged both hit and evicted");

    // right after an invalidate the array is empty, so no lookup can hit
    a_inval_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == OP_INVAL) |=> !lookup.hit && !lookup.evicted)
        else $error("lookup hit or evicted right after invalidate");

    // backpressure to the request side only when both registers are full
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request side stalled without a full pipeline");

endmodule

/* sv/mwm_entries.sv */
// Entry array: parallel tag match, first-fit pick and move-to-front update.
module mwm_entries
    import mwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mwm_cmd_t    cmd,
    output mwm_lookup_t lookup
);

    tag_t            tag_reg   [WAYS];
    logic [WAYS-1:0] valid_reg;
    win_t            win_reg   [WAYS];

    logic [WAYS-1:0] match;
    logic            found;
    win_t            pick;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = !valid_reg[i] || (tag_reg[i] == cmd.tag);
        end
    end

    // First qualifying entry from the front; last entry when none qualifies
    always_comb
    begin
        found = 1'b0;
        pick  = IDX_W'(WAYS - 1);
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found && match[i])
            begin
                found = 1'b1;
                pick  = IDX_W'(i);
            end
        end
    end

    assign lookup.win     = win_reg[pick];
    assign lookup.hit     = found && valid_reg[pick];
    assign lookup.evicted = !found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                tag_reg[i] <= '0;
                win_reg[i] <= IDX_W'(i);
            end
        end
        else if (cmd.update)
        begin
            if (cmd.op == OP_INVAL)
            begin
                valid_reg <= '0;
            end
            else
            begin
                // entries ahead of the pick slide back one place
                for (int i = 1; i < WAYS; i++)
                begin
                    if (IDX_W'(i) <= pick)
                    begin
                        tag_reg[i]   <= tag_reg[i-1];
                        valid_reg[i] <= valid_reg[i-1];
                        win_reg[i]   <= win_reg[i-1];
                    end
                end
                tag_reg[0]   <= cmd.tag;
                valid_reg[0] <= 1'b1;
                win_reg[0]   <= win_reg[pick];
            end
        end
    end

endmodule

/* sim/tb_mru_window_map_cache.sv */
// Self-checking testbench for the MRU window map cache: random/directed map traffic vs. a predictor.
`timescale 1ns / 100ps

module tb_mru_window_map_cache;
    import mwm_pkg::*;

    // One request item and one result item, at the block's widths
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
    } map_req_t;

    typedef struct packed {
        logic [WIN_IDX_W-1:0] win;
        logic [WIN_OFF_W-1:0] off;
        logic                 hit;
        logic                 evicted;
    } map_rsp_t;

    localparam int RANDOM_PER_PHASE = 282;
    localparam int HOLD_CYCLES      = 40;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no accept on either side
    localparam int SETTLE_CYCLES    = 8;     // margin for results still in the block
    localparam int MAX_REPORTS      = 10;

    // Idle percentages per phase: none, sender idle, receiver stall, both
    localparam int SEND_IDLE [4] = '{0, 59, 0, 15};
    localparam int RECV_STALL[4] = '{0, 0, 59, 15};

    logic clk;
    logic rst_n;

    mwm_req_if req_ch ();
    mwm_rsp_if rsp_ch ();

    mru_window_map_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Items waiting to be offered, and results owed by the block, oldest first
    map_req_t map_pending  [$];
    map_rsp_t window_owed  [$];

    // Predictor's copy of the entry array, front of the MRU order at index 0
    tag_t ent_tag [WAYS];
    logic ent_vld [WAYS];
    win_t ent_win [WAYS];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic hold_on = 1'b0;
    event hold_go;

    // Lookup and move-to-front on the predictor's entry array.
    // Scan front to back for the first free entry or a valid tag match;
    // with neither, the last entry is the victim. The chosen entry keeps its
    // window number and moves to the front, the ones ahead of it shift back.
    function automatic map_rsp_t window_lookup(map_req_t r);
        map_rsp_t          res;
        logic [ADDR_W-1:0] a;
        tag_t              t;
        win_t              w;
        int                pick;
        int                i;
        res  = '0;
        a    = r.addr & ~ADDR_W'(3);
        t    = a[ADDR_W-1:OFFSET_BITS];
        pick = -1;
        if (r.op == OP_INVAL)
        begin
            // tags and window order stay, only the valid bits drop
            for (i = 0; i < WAYS; i++)
                ent_vld[i] = 1'b0;
            return res;
        end
        for (i = 0; i < WAYS; i++)
        begin
            if (pick < 0 && (!ent_vld[i] || ent_tag[i] == t))
            begin
                pick    = i;
                res.hit = ent_vld[i];
            end
        end
        if (pick < 0)
        begin
            pick        = WAYS - 1;
            res.evicted = 1'b1;
        end
        w = ent_win[pick];
        for (i = pick; i > 0; i--)
        begin
            ent_tag[i] = ent_tag[i-1];
            ent_vld[i] = ent_vld[i-1];
            ent_win[i] = ent_win[i-1];
        end
        ent_tag[0] = t;
        ent_vld[0] = 1'b1;
        ent_win[0] = w;
        res.win = WIN_IDX_W'(w);
        res.off = a[WIN_OFF_W-1:0];
        return res;
    endfunction

    function automatic void queue_map(logic op, logic [ADDR_W-1:0] a);
        map_pending.push_back(map_req_t'{op, a});
    endfunction

    // Sender pause: nothing left to offer, nothing in flight, nothing owed
    task automatic drain_wait();
        do
            @(negedge clk);
        while (map_pending.size() != 0 || req_ch.valid || window_owed.size() != 0);
    endtask

    // Request driver. On accept the item goes through the predictor at once,
    // so predictor order equals acceptance order. A new item (or idle) is
    // picked only when the current one has gone or nothing is offered.
    always @(posedge clk)
    begin : request_driver
        map_req_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                window_owed.push_back(window_lookup(map_req_t'{req_ch.op, req_ch.phys_addr}));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (map_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = map_pending.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.op        <= nxt.op;
                    req_ch.phys_addr <= nxt.addr;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and ready generation
    always @(posedge clk)
    begin : result_monitor
        map_rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (window_owed.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with nothing owed: win=%0d off=%h hit=%b ev=%b",
                                 $realtime, rsp_ch.window_index, rsp_ch.window_offset,
                                 rsp_ch.hit, rsp_ch.evicted);
                end
                else
                begin
                    want = window_owed.pop_front();
                    if (rsp_ch.window_index !== want.win || rsp_ch.window_offset !== want.off ||
                        rsp_ch.hit !== want.hit || rsp_ch.evicted !== want.evicted)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch exp win=%0d off=%h hit=%b ev=%b, got win=%0d off=%h hit=%b ev=%b",
                                     $realtime, want.win, want.off, want.hit, want.evicted,
                                     rsp_ch.window_index, rsp_ch.window_offset,
                                     rsp_ch.hit, rsp_ch.evicted);
                    end
                end
            end
            rsp_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long hold-off: receiver stays stalled while the sender keeps offering,
    // so both pipeline registers fill and req.ready drops
    always
    begin : long_hold
        @(hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        tag_t base_pool [16];
        int   p;
        int   k;
        int   pool_n;
        int   roll;
        rst_n            = 1'b0;
        clk              = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_MAP;
        req_ch.phys_addr = '0;
        rsp_ch.ready     = 1'b0;
        for (k = 0; k < WAYS; k++)
        begin
            ent_tag[k] = '0;
            ent_vld[k] = 1'b0;
            ent_win[k] = win_t'(k);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: free-entry fill, byte bits ignored, offset extremes,
        // hit, eviction of the last entry, invalidate and refill with kept
        // window order, invalidate on an empty array
        queue_map(OP_MAP,   32'h0000_0000);
        queue_map(OP_MAP,   32'h0000_0003);
        queue_map(OP_MAP,   32'hFFFF_FFFF);
        queue_map(OP_MAP,   32'h0000_7FFF);
        queue_map(OP_MAP,   32'h0000_8000);
        queue_map(OP_MAP,   32'h0001_1234);
        queue_map(OP_MAP,   32'h0001_8004);
        queue_map(OP_MAP,   32'h0002_0ABC);
        queue_map(OP_MAP,   32'h0002_8FF0);
        queue_map(OP_MAP,   32'h0003_0001);
        queue_map(OP_MAP,   32'h0003_8002);
        queue_map(OP_MAP,   32'h0000_0100);
        queue_map(OP_MAP,   32'hFFFF_8000);
        queue_map(OP_INVAL, 32'hFFFF_FFFF);
        queue_map(OP_MAP,   32'h0001_1234);
        queue_map(OP_MAP,   32'h1234_5678);
        queue_map(OP_MAP,   32'h1234_5678);
        queue_map(OP_INVAL, 32'h0000_0000);
        queue_map(OP_INVAL, 32'h5A5A_A5A5);
        queue_map(OP_MAP,   32'hFFFF_FFFC);
        queue_map(OP_MAP,   32'h0000_4000);
        queue_map(OP_MAP,   32'hAAAA_AAAA);
        queue_map(OP_MAP,   32'h5555_5555);
        drain_wait();

        // Random phases. Most requests reuse a small pool of bases so that
        // hits, misses into free entries and evictions all stay frequent.
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            pool_n = $urandom_range(16, 6);
            for (k = 0; k < pool_n; k++)
                base_pool[k] = TAG_W'($urandom());
            base_pool[0] = '0;
            base_pool[1] = '1;
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    queue_map(OP_INVAL, $urandom());
                else if (roll < 20)
                    queue_map(OP_MAP, $urandom());
                else
                    queue_map(OP_MAP, {base_pool[$urandom_range(pool_n - 1)],
                                       OFFSET_BITS'($urandom())});
            end
            if (p == 0)
                -> hold_go;
            drain_wait();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && window_owed.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
